>>> design/uts_pkg.sv
// Shared types and constants for the time-slice scheduler.
package uts_pkg;

  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned UTIL_W    = 8;
  localparam int unsigned BUDGET_W  = 24;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DCNT_W    = 5;

  typedef enum logic [1:0] {
    REQ_HINT   = 2'd0,
    REQ_STATUS = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_PASS   = 2'd3
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMESLICE = 2'd0,
    CFG_DEFAULT   = 2'd1,
    CFG_UTIL_MIN  = 2'd2,
    CFG_UTIL_MAX  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic scan;
    logic mul;
    logic div;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic is_pass;
    logic need_scan;
    logic scan_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

>>> design/uts_if.sv
// Request and result channel interfaces.
interface uts_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [uts_pkg::SLOT_W-1:0]    slot;
  logic [uts_pkg::UTIL_W-1:0]    util_value;
  logic                          present;
  logic                          ready_req;
  modport source (output valid, req_type, slot, util_value, present, ready_req,
                  input ready);
  modport sink (input valid, req_type, slot, util_value, present, ready_req,
                output ready);
endinterface

interface uts_res_if;
  logic                          valid;
  logic                          ready;
  logic                          running_valid;
  logic [uts_pkg::SLOT_W-1:0]    running_slot;
  logic                          switched;
  logic [uts_pkg::BUDGET_W-1:0]  budget_left;
  logic                          hint_rejected;
  modport source (output valid, running_valid, running_slot, switched, budget_left,
                  hint_rejected, input ready);
  modport sink (input valid, running_valid, running_slot, switched, budget_left,
                hint_rejected, output ready);
endinterface

>>> design/utilization_time_slice_scheduler.sv
// Weighted round-robin time-slice scheduler, top level.
//
// Items arrive on req_i: weight hints, status updates, ticks and schedule
// passes. Every item yields exactly one result on res_o: grant state, whether
// the item granted a slot anew, ticks left and the hint reject flag.
// Hints, status updates, ticks and passes that keep or drop the grant are
// answered on acceptance. A pass that must look for a new slot walks the slot
// table one slot a cycle summing the weights, multiplies, runs a 32-step
// restoring divider for the budget and finishes. Only one item is in flight;
// req_i.ready is high when the sequencer is idle and the result register is
// empty or being emptied, so a stalled receiver holds off new items and the
// result stays put until taken. Registers are written only while idle, by
// the user through cfg_we_i/cfg_idx_i/cfg_data_i; the block does not enforce
// it. Reset clears all slot state and the grant and loads the register
// defaults (timeslice 5000, default budget 5000, weight range 0 to 100).
module utilization_time_slice_scheduler #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [uts_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [uts_pkg::BUDGET_W-1:0]  cfg_data_i,
  uts_req_if.sink                       req_i,
  uts_res_if.source                     res_o
);

  uts_pkg::cmd_t cmd;
  uts_pkg::sts_t sts;

  uts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  uts_dp #(.SLOTS(SLOTS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_i.req_type),
    .slot_i          (req_i.slot),
    .util_value_i    (req_i.util_value),
    .present_i       (req_i.present),
    .ready_req_i     (req_i.ready_req),
    .out_ready_i     (res_o.ready),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (res_o.valid),
    .running_valid_o (res_o.running_valid),
    .running_slot_o  (res_o.running_slot),
    .switched_o      (res_o.switched),
    .budget_left_o   (res_o.budget_left),
    .hint_rejected_o (res_o.hint_rejected)
  );

  assign req_i.ready = cmd.in_ready;

  a_ready_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> (!res_o.valid || res_o.ready))
    else $error("input taken while result register is blocked");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.scan || cmd.mul || cmd.div || cmd.fin) |-> !req_i.ready)
    else $error("input ready during a search");

  a_switch_grants: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.switched) |-> res_o.running_valid)
    else $error("switch reported without a grant");

  a_idle_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.running_valid) |-> (res_o.running_slot == '0))
    else $error("slot shown without a grant");

endmodule

>>> design/uts_ctrl.sv
// Sequencer for the time-slice scheduler: scan, multiply, divide, finish.
module uts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  uts_pkg::sts_t  sts_i,
  output uts_pkg::cmd_t  cmd_o
);

  uts_pkg::state_e state_q, state_d;
  logic            accept;

  assign accept = in_valid_i && (state_q == uts_pkg::ST_IDLE) && sts_i.out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      uts_pkg::ST_IDLE: begin
        if (accept && sts_i.is_pass && sts_i.need_scan) state_d = uts_pkg::ST_SCAN;
      end
      uts_pkg::ST_SCAN: begin
        if (sts_i.scan_last) state_d = uts_pkg::ST_MUL;
      end
      uts_pkg::ST_MUL: state_d = uts_pkg::ST_DIV;
      uts_pkg::ST_DIV: begin
        if (sts_i.div_last) state_d = uts_pkg::ST_FIN;
      end
      uts_pkg::ST_FIN: state_d = uts_pkg::ST_IDLE;
      default: state_d = uts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.in_ready = (state_q == uts_pkg::ST_IDLE) && sts_i.out_free;
    cmd_o.accept   = accept;
    case (state_q)
      uts_pkg::ST_SCAN: cmd_o.scan = 1'b1;
      uts_pkg::ST_MUL:  cmd_o.mul  = 1'b1;
      uts_pkg::ST_DIV:  cmd_o.div  = 1'b1;
      uts_pkg::ST_FIN:  cmd_o.fin  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= uts_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

endmodule

>>> design/uts_dp.sv
// Datapath: slot tables, grant state, weight sum, budget divider, result register.
module uts_dp #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [uts_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [uts_pkg::BUDGET_W-1:0]  cfg_data_i,
  input  logic [1:0]                    req_type_i,
  input  logic [uts_pkg::SLOT_W-1:0]    slot_i,
  input  logic [uts_pkg::UTIL_W-1:0]    util_value_i,
  input  logic                          present_i,
  input  logic                          ready_req_i,
  input  logic                          out_ready_i,
  input  uts_pkg::cmd_t                 cmd_i,
  output uts_pkg::sts_t                 sts_o,
  output logic                          out_valid_o,
  output logic                          running_valid_o,
  output logic [uts_pkg::SLOT_W-1:0]    running_slot_o,
  output logic                          switched_o,
  output logic [uts_pkg::BUDGET_W-1:0]  budget_left_o,
  output logic                          hint_rejected_o
);

  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SUM_W = $clog2(SLOTS * 255 + 1);
  localparam int unsigned BW    = uts_pkg::BUDGET_W;
  localparam int unsigned PW    = uts_pkg::PROD_W;

  logic [BW-1:0] ts_q, def_q;
  logic [uts_pkg::UTIL_W-1:0] umin_q, umax_q;

  logic [uts_pkg::UTIL_W-1:0] wt_q [SLOTS];
  logic [SLOTS-1:0] wv_q, pres_q, rdy_q;
  logic             gv_q;
  logic [SW-1:0]    gs_q;
  logic [BW-1:0]    bud_q;

  logic [SW-1:0]    idx_q, k_q, cand_q;
  logic             found_q, excl_q;
  logic [uts_pkg::UTIL_W-1:0] cw_q;
  logic [SUM_W-1:0] sum_q, rem_q;
  logic [PW-1:0]    dq_q;
  logic [uts_pkg::DCNT_W-1:0] dcnt_q;

  logic             ov_q, o_gv_q, o_sw_q, o_rej_q;
  logic [uts_pkg::SLOT_W-1:0] o_gs_q;
  logic [BW-1:0]    o_bud_q;

  // decode of the incoming item
  logic          is_hint, is_status, is_tick, is_pass, slot_ok, rejected;
  logic [SW-1:0] widx;
  logic [SLOTS-1:0] wv_drop;
  logic          any_w, gv_keep, cur_ready, need_scan, scan_excl;
  logic [SW-1:0] start_idx;
  logic          gv_nx;
  logic [BW-1:0] bud_nx;

  assign is_hint   = (req_type_i == uts_pkg::REQ_HINT);
  assign is_status = (req_type_i == uts_pkg::REQ_STATUS);
  assign is_tick   = (req_type_i == uts_pkg::REQ_TICK);
  assign is_pass   = (req_type_i == uts_pkg::REQ_PASS);
  assign slot_ok   = (32'(slot_i) < SLOTS);
  assign widx      = SW'(slot_i);
  assign rejected  = (util_value_i < umin_q) || (util_value_i > umax_q);

  assign wv_drop   = wv_q & pres_q;
  assign any_w     = |wv_drop;
  assign gv_keep   = gv_q && pres_q[gs_q];
  assign cur_ready = pres_q[gs_q] && rdy_q[gs_q];

  always_comb begin
    need_scan = 1'b0;
    scan_excl = 1'b0;
    start_idx = '0;
    if (any_w) begin
      if (!gv_keep) begin
        need_scan = 1'b1;
      end else if (!((bud_q != '0) && cur_ready)) begin
        need_scan = 1'b1;
        if (wv_drop[gs_q]) begin
          // round robin from the slot after the current one; current slot is excluded
          scan_excl = 1'b1;
          start_idx = (gs_q == SW'(SLOTS - 1)) ? '0 : gs_q + SW'(1);
        end
      end
    end
  end

  always_comb begin
    gv_nx  = gv_q;
    bud_nx = bud_q;
    if (is_tick && (bud_q != '0)) bud_nx = bud_q - BW'(1);
    if (is_pass) gv_nx = gv_keep;
  end

  // scan eligibility for the slot under the pointer
  logic elig;
  assign elig = pres_q[idx_q] && rdy_q[idx_q] && wv_q[idx_q] &&
                !(excl_q && (idx_q == gs_q));

  // one restoring division step
  logic [SUM_W:0] trial;
  logic           qbit;
  assign trial = {rem_q, dq_q[PW-1]};
  assign qbit  = (trial >= {1'b0, sum_q});

  assign sts_o.is_pass   = is_pass;
  assign sts_o.need_scan = need_scan;
  assign sts_o.scan_last = (k_q == SW'(SLOTS - 1));
  assign sts_o.div_last  = (dcnt_q == '1);
  assign sts_o.out_free  = !ov_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q   <= BW'(5000);
      def_q  <= BW'(5000);
      umin_q <= '0;
      umax_q <= uts_pkg::UTIL_W'(100);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        uts_pkg::CFG_TIMESLICE: ts_q   <= cfg_data_i;
        uts_pkg::CFG_DEFAULT:   def_q  <= cfg_data_i;
        uts_pkg::CFG_UTIL_MIN:  umin_q <= cfg_data_i[uts_pkg::UTIL_W-1:0];
        uts_pkg::CFG_UTIL_MAX:  umax_q <= cfg_data_i[uts_pkg::UTIL_W-1:0];
        default: ;
      endcase
    end
  end

  // weight values only matter where wv_q is set, so no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && is_hint && !rejected && slot_ok) wt_q[widx] <= util_value_i;
    if (cmd_i.scan && !found_q && elig) cw_q <= wt_q[idx_q];
    if (cmd_i.scan) begin
      if (wv_q[idx_q]) sum_q <= sum_q + SUM_W'(wt_q[idx_q]);
    end else if (cmd_i.accept) begin
      sum_q <= '0;
    end
    if (cmd_i.mul) begin
      dq_q  <= PW'(ts_q * cw_q);
      rem_q <= '0;
    end else if (cmd_i.div) begin
      rem_q <= qbit ? SUM_W'(trial - {1'b0, sum_q}) : trial[SUM_W-1:0];
      dq_q  <= {dq_q[PW-2:0], qbit};
    end
    if (cmd_i.accept) begin
      idx_q  <= start_idx;
      excl_q <= scan_excl;
    end else if (cmd_i.scan) begin
      idx_q <= (idx_q == SW'(SLOTS - 1)) ? '0 : idx_q + SW'(1);
      if (!found_q && elig) cand_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q    <= '0;
      pres_q  <= '0;
      rdy_q   <= '0;
      gv_q    <= 1'b0;
      gs_q    <= '0;
      bud_q   <= '0;
      k_q     <= '0;
      found_q <= 1'b0;
      dcnt_q  <= '0;
      ov_q    <= 1'b0;
      o_gv_q  <= 1'b0;
      o_gs_q  <= '0;
      o_sw_q  <= 1'b0;
      o_bud_q <= '0;
      o_rej_q <= 1'b0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (cmd_i.accept) begin
        k_q     <= '0;
        found_q <= 1'b0;
        gv_q    <= gv_nx;
        bud_q   <= bud_nx;
        if (is_hint && !rejected && slot_ok) wv_q[widx] <= 1'b1;
        if (is_status && slot_ok) begin
          pres_q[widx] <= present_i;
          rdy_q[widx]  <= ready_req_i;
        end
        if (is_pass) wv_q <= wv_drop;
        if (!(is_pass && need_scan)) begin
          ov_q    <= 1'b1;
          o_gv_q  <= gv_nx;
          o_gs_q  <= gv_nx ? uts_pkg::SLOT_W'(gs_q) : '0;
          o_sw_q  <= 1'b0;
          o_bud_q <= bud_nx;
          o_rej_q <= is_hint && rejected;
        end
      end
      if (cmd_i.scan) begin
        k_q <= k_q + SW'(1);
        if (elig) found_q <= 1'b1;
      end
      if (cmd_i.mul) dcnt_q <= '0;
      if (cmd_i.div) dcnt_q <= dcnt_q + uts_pkg::DCNT_W'(1);
      if (cmd_i.fin) begin
        ov_q    <= 1'b1;
        o_rej_q <= 1'b0;
        o_sw_q  <= found_q;
        if (found_q) begin
          gv_q    <= 1'b1;
          gs_q    <= cand_q;
          bud_q   <= (sum_q == '0) ? def_q : dq_q[BW-1:0];
          o_gv_q  <= 1'b1;
          o_gs_q  <= uts_pkg::SLOT_W'(cand_q);
          o_bud_q <= (sum_q == '0) ? def_q : dq_q[BW-1:0];
        end else begin
          gv_q    <= 1'b0;
          o_gv_q  <= 1'b0;
          o_gs_q  <= '0;
          o_bud_q <= bud_q;
        end
      end
    end
  end

  assign out_valid_o     = ov_q;
  assign running_valid_o = o_gv_q;
  assign running_slot_o  = o_gs_q;
  assign switched_o      = o_sw_q;
  assign budget_left_o   = o_bud_q;
  assign hint_rejected_o = o_rej_q;

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the weighted round-robin time-slice scheduler.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import uts_pkg::*;

  localparam int unsigned NSLOT = 16;

  typedef struct packed {
    req_type_e             kind;
    logic [SLOT_W-1:0]     slot;
    logic [UTIL_W-1:0]     util;
    logic                  present;
    logic                  rdy;
  } sched_req_t;

  typedef struct packed {
    logic                  run_valid;
    logic [SLOT_W-1:0]     run_slot;
    logic                  switched;
    logic [BUDGET_W-1:0]   budget;
    logic                  rejected;
  } grant_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [BUDGET_W-1:0] cfg_data_i = '0;

  uts_req_if req ();
  uts_res_if res ();

  utilization_time_slice_scheduler #(.SLOTS(NSLOT)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_i(req.sink), .res_o(res.source)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the block's registers and slot table
  logic [BUDGET_W-1:0] m_timeslice = 24'd5000;
  logic [BUDGET_W-1:0] m_default = 24'd5000;
  logic [UTIL_W-1:0]   m_umin = 8'd0;
  logic [UTIL_W-1:0]   m_umax = 8'd100;
  logic [UTIL_W-1:0]   m_weight [NSLOT];
  logic                m_wvalid [NSLOT];
  logic                m_present [NSLOT];
  logic                m_ready [NSLOT];
  logic                m_gvalid = 1'b0;
  logic [SLOT_W-1:0]   m_gslot = '0;
  logic [BUDGET_W-1:0] m_budget = '0;

  grant_state_t grant_expect_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      m_weight[i] = '0; m_wvalid[i] = 1'b0; m_present[i] = 1'b0; m_ready[i] = 1'b0;
    end
  end

  function automatic logic slot_runnable(int s);
    return m_present[s] && m_ready[s];
  endfunction

  function automatic void grant_slot_to(int s);
    longint total;
    longint prod;
    total = 0;
    for (int i = 0; i < NSLOT; i++)
      if (m_wvalid[i]) total += m_weight[i];
    m_gvalid = 1'b1;
    m_gslot = SLOT_W'(s);
    if (total == 0) begin
      m_budget = m_default;
    end else begin
      prod = longint'(m_timeslice) * longint'(m_weight[s]);
      m_budget = BUDGET_W'(prod / total);
    end
  endfunction

  function automatic logic grant_lowest();
    m_gvalid = 1'b0;
    for (int i = 0; i < NSLOT; i++)
      if (slot_runnable(i) && m_wvalid[i]) begin
        grant_slot_to(i);
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function automatic logic schedule_pass();
    logic any;
    int s;
    any = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      if (!m_present[i]) m_wvalid[i] = 1'b0;
      if (m_wvalid[i]) any = 1'b1;
    end
    if (m_gvalid && !m_present[m_gslot]) m_gvalid = 1'b0;
    if (!any) return 1'b0;
    if (!m_gvalid) return grant_lowest();
    if (m_budget > 0 && slot_runnable(m_gslot)) return 1'b0;
    if (!m_wvalid[m_gslot]) return grant_lowest();
    for (int k = 1; k < NSLOT; k++) begin
      s = (int'(m_gslot) + k) % NSLOT;
      if (slot_runnable(s) && m_wvalid[s]) begin
        grant_slot_to(s);
        return 1'b1;
      end
    end
    m_gvalid = 1'b0;
    return 1'b0;
  endfunction

  function automatic grant_state_t sched_predict(sched_req_t it);
    grant_state_t r;
    r = '0;
    case (it.kind)
      REQ_HINT: begin
        if (it.util < m_umin || it.util > m_umax) begin
          r.rejected = 1'b1;
        end else begin
          m_weight[it.slot] = it.util;
          m_wvalid[it.slot] = 1'b1;
        end
      end
      REQ_STATUS: begin
        m_present[it.slot] = it.present;
        m_ready[it.slot] = it.rdy;
      end
      REQ_TICK: if (m_budget > 0) m_budget = m_budget - 1'b1;
      default: r.switched = schedule_pass();
    endcase
    r.run_valid = m_gvalid;
    r.run_slot = m_gvalid ? m_gslot : '0;
    r.budget = m_budget;
    return r;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // result check first, then expectation of the item taken at the same edge
  always @(posedge clk_i) begin
    grant_state_t want;
    sched_req_t it;
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        if (grant_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual slot %0d budget %0d", $time,
                   res.running_slot, res.budget_left);
        end else begin
          want = grant_expect_q.pop_front();
          check_field("running_valid", want.run_valid, res.running_valid);
          check_field("running_slot", want.run_slot, res.running_slot);
          check_field("switched", want.switched, res.switched);
          check_field("budget_left", want.budget, res.budget_left);
          check_field("hint_rejected", want.rejected, res.hint_rejected);
        end
      end
      if (req.valid && req.ready) begin
        it.kind = req_type_e'(req.req_type);
        it.slot = req.slot;
        it.util = req.util_value;
        it.present = req.present;
        it.rdy = req.ready_req;
        grant_expect_q.insert(grant_expect_q.size(), sched_predict(it));
      end
    end
  end

  // receiver: random stalls, or a long hold-off while hold_left counts down
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      res.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      res.ready <= ($urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;
    end
  end

  task automatic send_item(sched_req_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid <= 1'b1;
    req.req_type <= it.kind;
    req.slot <= it.slot;
    req.util_value <= it.util;
    req.present <= it.present;
    req.ready_req <= it.rdy;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic send(req_type_e k, int s = 0, int u = 0, bit p = 0, bit r = 0);
    sched_req_t it;
    it.kind = k; it.slot = SLOT_W'(s); it.util = UTIL_W'(u);
    it.present = p; it.rdy = r;
    send_item(it);
  endtask

  // sender pause until every expected item result is back
  task automatic drain();
    @(negedge clk_i);
    req.valid <= 1'b0;
    while (grant_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= BUDGET_W'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TIMESLICE: m_timeslice = BUDGET_W'(val);
      CFG_DEFAULT:   m_default = BUDGET_W'(val);
      CFG_UTIL_MIN:  m_umin = UTIL_W'(val);
      default:       m_umax = UTIL_W'(val);
    endcase
  endtask

  task automatic configure(int unsigned ts, int unsigned dflt, int unsigned lo, int unsigned hi);
    cfg_write(CFG_TIMESLICE, ts);
    cfg_write(CFG_DEFAULT, dflt);
    cfg_write(CFG_UTIL_MIN, lo);
    cfg_write(CFG_UTIL_MAX, hi);
  endtask

  function automatic sched_req_t rand_item();
    sched_req_t it;
    int pick;
    it.slot = SLOT_W'($urandom_range(NSLOT - 1));
    it.util = UTIL_W'($urandom_range(255));
    it.present = ($urandom_range(99) < 85);
    it.rdy = ($urandom_range(99) < 75);
    pick = $urandom_range(99);
    if (pick < 20) begin
      it.kind = REQ_HINT;
      // mostly accepted weights, the rest anywhere
      if (m_umin <= m_umax && $urandom_range(99) < 80)
        it.util = UTIL_W'($urandom_range(m_umax, m_umin));
    end else if (pick < 40) it.kind = REQ_STATUS;
    else if (pick < 75) it.kind = REQ_TICK;
    else it.kind = REQ_PASS;
    return it;
  endfunction

  task automatic test_directed();
    send(REQ_TICK);                       // tick at zero
    send(REQ_PASS);                       // no weights
    send(REQ_HINT, 3, 101);               // above max
    send(REQ_HINT, 3, 255);
    send(REQ_HINT, 0, 0);
    send(REQ_HINT, 15, 100);
    send(REQ_STATUS, 15, 0, 0, 1);        // ready without presence
    send(REQ_STATUS, 0, 0, 1, 1);
    send(REQ_PASS);                       // slot 15 absent: weight dropped
    send(REQ_HINT, 15, 100);
    send(REQ_STATUS, 15, 0, 1, 1);
    send(REQ_PASS);                       // budget left, stay
    repeat (3) send(REQ_TICK);
    send(REQ_STATUS, 0, 0, 1, 0);
    send(REQ_PASS);                       // current not ready: move on to slot 15
    send(REQ_STATUS, 15, 0, 0, 0);
    send(REQ_PASS);                       // grant dropped, no candidate
    drain();
    configure(24'hFFFFFF, 0, 200, 10);    // min above max
    send(REQ_HINT, 4, 50);
    send(REQ_HINT, 4, 200);
    send(REQ_STATUS, 0, 0, 1, 1);
    send(REQ_PASS);
    drain();
  endtask

  task automatic test_random(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      send_item(rand_item());
      if ($urandom_range(199) == 0) drain();
    end
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    hold_left = 400;
    for (int i = 0; i < 30; i++) send_item(rand_item());
    drain();
  endtask

  initial begin
    req.valid = 1'b0; req.req_type = REQ_HINT; req.slot = '0;
    req.util_value = '0; req.present = 1'b0; req.ready_req = 1'b0;
    res.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    configure(60, 7, 0, 100);
    test_random(480, 0, 0);
    configure(24'hFFFFFF, 24'hFFFFFF, 10, 200);
    test_random(480, 80, 0);
    test_backpressure();
    configure(0, 0, 0, 255);
    test_random(480, 0, 80);
    configure(200, 30, 5, 50);
    test_random(480, 11, 11);
    while (grant_expect_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
